### src/kls_pkg.sv
// kls_pkg: shared types and widths for the k-th largest selection block.
// No dependencies; used by kls_cell and kth_largest_selection.
package kls_pkg;

   localparam int VALUE_W = 32;
   localparam int CFG_W   = 7;

   typedef logic signed [VALUE_W-1:0] value_type;

   // What one cell hands to the next one down the row
   typedef struct packed {
      logic      valid;
      logic      take;
      value_type value;
   } link_type;

endpackage

### src/kls_cell.sv
// kls_cell: one entry of the descending sorted row, with its compare-and-shift step.
// Depends on kls_pkg.
module kls_cell
   import kls_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      clear,
   input  logic      shift_en,
   input  logic      active,
   input  value_type in_value,
   input  link_type  prev,
   output link_type  this_link
);

   logic      valid_ff, valid_in;
   value_type value_ff, value_in;
   logic      greater;
   logic      take;

   // an empty entry counts as smaller than anything
   assign greater = !valid_ff || (in_value > value_ff);
   assign take    = active && greater;

   // a shifted-in entry keeps the validity of the entry it came from
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (clear) begin
         valid_in = 1'b0;
      end else if (shift_en && take) begin
         valid_in = prev.take ? prev.valid : 1'b1;
         value_in = prev.take ? prev.value : in_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign this_link.valid = valid_ff;
   assign this_link.take  = take;
   assign this_link.value = value_ff;

endmodule

### src/kth_largest_selection.sv
// kth_largest_selection: keeps the k largest values of a set in a row of
// compare-and-shift cells and reports the k-th largest on the last item.
// Depends on kls_pkg and kls_cell.
// Throughput: one item per cycle; each last item sets a pending flag that stalls
// input until the output register takes the result, which waits while an
// earlier result is still held there.
// Reset (synchronous): rank 1, row empty, no result pending.
module kth_largest_selection
   import kls_pkg::*;
#(
   parameter int KEEP_MAX = 64
) (
   input  logic               clock,
   input  logic               reset,
   // configuration: keep_count
   input  logic               csr_we,
   input  logic [CFG_W-1:0]   csr_wdata,
   // input items
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [VALUE_W-1:0] req_tdata,   // [31:0] sample_value
   input  logic               req_tlast,   // last_item
   // results
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [VALUE_W-1:0] rsp_tdata,   // [31:0] kth_value
   output logic               rsp_tuser    // [0] enough_items
);

   localparam int IDXW = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1;

   logic [IDXW-1:0]    rank_idx_ff, rank_idx_in;
   logic               pending_ff, pending_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in;

   logic      accept;
   logic      transfer;
   logic      clear;
   value_type sample;
   link_type  links [KEEP_MAX];
   link_type  sel_link;

   assign req_tready = !pending_ff;
   assign accept     = req_tvalid && req_tready;
   assign transfer   = pending_ff && (!rsp_valid_ff || rsp_tready);
   assign clear      = csr_we || transfer;
   assign sample     = value_type'(req_tdata);

   genvar i;
   generate
      for (i = 0; i < KEEP_MAX; i++) begin : g_cell
         link_type prev_link;
         if (i == 0) begin : g_head
            assign prev_link = '0;
         end else begin : g_body
            assign prev_link = links[i-1];
         end
         kls_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .clear     (clear),
            .shift_en  (accept),
            .active    (IDXW'(i) <= rank_idx_ff),
            .in_value  (sample),
            .prev      (prev_link),
            .this_link (links[i])
         );
      end
   endgenerate

   assign sel_link = links[rank_idx_ff];

   // rank 0 acts as 1, anything above the row length saturates
   always_comb begin
      rank_idx_in = rank_idx_ff;
      if (csr_we) begin
         if (csr_wdata == '0) begin
            rank_idx_in = '0;
         end else if (32'(csr_wdata) > 32'(KEEP_MAX)) begin
            rank_idx_in = IDXW'(KEEP_MAX - 1);
         end else begin
            rank_idx_in = IDXW'(csr_wdata - CFG_W'(1));
         end
      end
   end

   always_comb begin
      pending_in = pending_ff;
      if (accept && req_tlast) begin
         pending_in = 1'b1;
      end else if (transfer) begin
         pending_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (transfer) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = sel_link.valid;
         rsp_data_in  = sel_link.valid ? sel_link.value : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_idx_ff  <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rank_idx_ff  <= rank_idx_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
